>>> hw/rtl/vat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vat_pkg
// Shared constants, types and helpers for the viewbox aspect transform.
// ----------------------------------------------------------------------------
package vat_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int W_ORG      = 32;
    localparam int W_EXT      = 31;
    localparam int W_S        = 32;
    localparam int W_DVD      = W_EXT + FRAC_BITS;
    localparam int W_TRY      = W_EXT + W_S;
    localparam int DIV_STAGES = W_S;
    localparam int W_PROD     = W_ORG + W_S + 1;
    localparam int W_PEXT     = W_EXT + W_S;
    localparam int W_Q        = W_PROD - FRAC_BITS;
    localparam int W_SUM      = W_Q + 2;
    localparam int W_CFG_IDX  = 3;
    localparam int W_ALIGN    = 4;

    localparam logic [W_CFG_IDX-1:0] CFG_VIEW_X = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_VIEW_Y = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_VIEW_W = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_VIEW_H = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_ALIGN  = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_FIT    = 3'd5;

    localparam logic FIT_MEET  = 1'b0;
    localparam logic FIT_SLICE = 1'b1;

    typedef logic [1:0] t_pos;
    localparam t_pos POS_MIN  = 2'd0;
    localparam t_pos POS_MID  = 2'd1;
    localparam t_pos POS_MAX  = 2'd2;
    localparam t_pos POS_NONE = 2'd3;

    typedef struct packed {
        t_pos col;
        t_pos row;
    } t_align;

    typedef struct packed {
        logic signed [W_ORG-1:0] bx;
        logic signed [W_ORG-1:0] by;
        logic [W_EXT-1:0]        bw;
        logic [W_EXT-1:0]        bh;
        logic                    ovf_x;
        logic                    ovf_y;
        logic                    zero;
    } t_side;

    function automatic t_align align_decode(input logic [W_ALIGN-1:0] mode);
        t_align a;
        unique case (mode)
            4'd1:    a = '{POS_MIN, POS_MIN};
            4'd2:    a = '{POS_MID, POS_MIN};
            4'd3:    a = '{POS_MAX, POS_MIN};
            4'd4:    a = '{POS_MIN, POS_MID};
            4'd5:    a = '{POS_MID, POS_MID};
            4'd6:    a = '{POS_MAX, POS_MID};
            4'd7:    a = '{POS_MIN, POS_MAX};
            4'd8:    a = '{POS_MID, POS_MAX};
            4'd9:    a = '{POS_MAX, POS_MAX};
            default: a = '{POS_NONE, POS_NONE};
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/vat_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vat_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vat_div
    import vat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W_DVD-1:0] i_dvd,
    input  logic [W_EXT-1:0] i_dvs,
    output logic [W_S-1:0]   o_q
);

    logic [W_DVD-1:0] r_rem [DIV_STAGES];
    logic [W_EXT-1:0] r_dvs [DIV_STAGES];
    logic [W_S-1:0]   r_q   [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stage
            localparam int K = DIV_STAGES - 1 - g;
            logic [W_DVD-1:0] rem_in;
            logic [W_EXT-1:0] dvs_in;
            logic [W_S-1:0]   q_in;
            logic [W_TRY-1:0] shd;
            logic [W_TRY-1:0] trial;
            logic             take;

            if (g == 0) begin : g_first
                assign rem_in = i_dvd;
                assign dvs_in = i_dvs;
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign dvs_in = r_dvs[g-1];
                assign q_in   = r_q[g-1];
            end

            assign shd   = W_TRY'(dvs_in) << K;
            assign take  = W_TRY'(rem_in) >= shd;
            assign trial = W_TRY'(rem_in) - shd;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= take ? trial[W_DVD-1:0] : rem_in;
                    r_dvs[g] <= dvs_in;
                    r_q[g]   <= q_in | (W_S'(take) << K);
                end
            end
        end
    endgenerate

    assign o_q = r_q[DIV_STAGES-1];

endmodule

>>> hw/rtl/viewbox_aspect_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// viewbox_aspect_transform
// Maps a source box onto the configured viewbox: scales and offsets.
// ----------------------------------------------------------------------------
// One request per cycle while not stalled: an input register, 32 divider
// stages (one quotient bit each), then scale select, multiply, offset and
// saturating output register. A stall on the output freezes the whole pipe.
// Configuration is sampled live, so write it only while the pipe is empty.
module viewbox_aspect_transform
    import vat_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [W_ORG-1:0] i_box_x,
    input  logic signed [W_ORG-1:0] i_box_y,
    input  logic [W_EXT-1:0]        i_box_w,
    input  logic [W_EXT-1:0]        i_box_h,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [W_S-1:0]          o_scale_x,
    output logic [W_S-1:0]          o_scale_y,
    output logic signed [W_ORG-1:0] o_offset_x,
    output logic signed [W_ORG-1:0] o_offset_y,
    output logic                    o_zero_extent,
    input  logic                    i_cfg_we,
    input  logic [W_CFG_IDX-1:0]    i_cfg_idx,
    input  logic [W_ORG-1:0]        i_cfg_data
);

    logic signed [W_ORG-1:0] r_view_x, r_view_y;
    logic [W_EXT-1:0]        r_view_w, r_view_h;
    logic [W_ALIGN-1:0]      r_align;
    logic                    r_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x <= '0;
            r_view_y <= '0;
            r_view_w <= W_EXT'(1) << FRAC_BITS;
            r_view_h <= W_EXT'(1) << FRAC_BITS;
            r_align  <= '0;
            r_fit    <= FIT_MEET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VIEW_X: r_view_x <= i_cfg_data;
                CFG_VIEW_Y: r_view_y <= i_cfg_data;
                CFG_VIEW_W: r_view_w <= i_cfg_data[W_EXT-1:0];
                CFG_VIEW_H: r_view_h <= i_cfg_data[W_EXT-1:0];
                CFG_ALIGN:  r_align  <= i_cfg_data[W_ALIGN-1:0];
                CFG_FIT:    r_fit    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_valid;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // input register
    logic  r_v0;
    t_side r_sb0;
    logic [W_DVD-1:0] dvd_x, dvd_y;
    assign dvd_x = {r_view_w, FRAC_BITS'(0)};
    assign dvd_y = {r_view_h, FRAC_BITS'(0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb0.bx    <= i_box_x;
            r_sb0.by    <= i_box_y;
            r_sb0.bw    <= i_box_w;
            r_sb0.bh    <= i_box_h;
            r_sb0.ovf_x <= W_TRY'({r_view_w, FRAC_BITS'(0)}) >= (W_TRY'(i_box_w) << W_S);
            r_sb0.ovf_y <= W_TRY'({r_view_h, FRAC_BITS'(0)}) >= (W_TRY'(i_box_h) << W_S);
            r_sb0.zero  <= (i_box_w == '0) || (i_box_h == '0);
        end
    end

    logic [W_S-1:0] q_x, q_y;

    vat_div u_div_x (.i_clk(i_clk), .i_en(en), .i_dvd(dvd_x), .i_dvs(r_sb0.bw), .o_q(q_x));
    vat_div u_div_y (.i_clk(i_clk), .i_en(en), .i_dvd(dvd_y), .i_dvs(r_sb0.bh), .o_q(q_y));

    logic  r_vd [DIV_STAGES];
    t_side r_sbd [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STAGES; i++) r_vd[i] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r_v0;
            for (int i = 1; i < DIV_STAGES; i++) r_vd[i] <= r_vd[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sbd[0] <= r_sb0;
            for (int i = 1; i < DIV_STAGES; i++) r_sbd[i] <= r_sbd[i-1];
        end
    end

    // scale select
    t_side          sbd;
    logic [W_S-1:0] sx, sy, usx, usy;
    logic           aligned, uniform, pick_x;
    t_align         al;
    t_pos           px, py;

    assign sbd     = r_sbd[DIV_STAGES-1];
    assign sx      = sbd.ovf_x ? '1 : q_x;
    assign sy      = sbd.ovf_y ? '1 : q_y;
    assign al      = align_decode(r_align);
    assign aligned = (al.col != POS_NONE);
    assign uniform = (r_fit == FIT_SLICE) || aligned;
    assign pick_x  = (r_fit == FIT_MEET) ? (sx < sy) : (sx > sy);

    always_comb begin
        usx = sx;
        usy = sy;
        px  = al.col;
        py  = al.row;
        if (uniform) begin
            if (pick_x) begin
                usy = sx;
                px  = POS_NONE;
            end else begin
                usx = sy;
                py  = POS_NONE;
            end
        end
    end

    logic           r_va;
    t_side          r_sba;
    logic [W_S-1:0] r_sx_a, r_sy_a;
    t_pos           r_px_a, r_py_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= r_vd[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sba  <= sbd;
            r_sx_a <= usx;
            r_sy_a <= usy;
            r_px_a <= px;
            r_py_a <= py;
        end
    end

    // multiply
    logic                     r_vb;
    logic                     r_zero_b;
    logic [W_S-1:0]           r_sx_b, r_sy_b;
    t_pos                     r_px_b, r_py_b;
    logic signed [W_PROD-1:0] r_qx_b, r_qy_b;
    logic [W_PEXT-1:0]        r_px_prod_b, r_py_prod_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero_b    <= r_sba.zero;
            r_sx_b      <= r_sx_a;
            r_sy_b      <= r_sy_a;
            r_px_b      <= r_px_a;
            r_py_b      <= r_py_a;
            r_qx_b      <= W_PROD'(r_sba.bx * $signed({1'b0, r_sx_a}));
            r_qy_b      <= W_PROD'(r_sba.by * $signed({1'b0, r_sy_a}));
            r_px_prod_b <= W_PEXT'(r_sba.bw) * W_PEXT'(r_sx_a);
            r_py_prod_b <= W_PEXT'(r_sba.bh) * W_PEXT'(r_sy_a);
        end
    end

    // base translation and alignment term
    logic signed [W_Q-1:0]   qx, qy, dx, dy;
    logic signed [W_SUM-1:0] tx, ty;

    assign qx = W_Q'(r_qx_b >>> FRAC_BITS);
    assign qy = W_Q'(r_qy_b >>> FRAC_BITS);
    assign dx = $signed(W_Q'(r_view_w)) - $signed(W_Q'(r_px_prod_b >> FRAC_BITS));
    assign dy = $signed(W_Q'(r_view_h)) - $signed(W_Q'(r_py_prod_b >> FRAC_BITS));

    always_comb begin
        unique case (r_px_b)
            POS_MID: tx = W_SUM'(dx >>> 1);
            POS_MAX: tx = W_SUM'(dx);
            default: tx = '0;
        endcase
        unique case (r_py_b)
            POS_MID: ty = W_SUM'(dy >>> 1);
            POS_MAX: ty = W_SUM'(dy);
            default: ty = '0;
        endcase
    end

    logic                    r_vc;
    logic                    r_zero_c;
    logic [W_S-1:0]          r_sx_c, r_sy_c;
    logic signed [W_SUM-1:0] r_bx_c, r_by_c, r_tx_c, r_ty_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero_c <= r_zero_b;
            r_sx_c   <= r_sx_b;
            r_sy_c   <= r_sy_b;
            r_bx_c   <= W_SUM'(r_view_x) - W_SUM'(qx);
            r_by_c   <= W_SUM'(r_view_y) - W_SUM'(qy);
            r_tx_c   <= tx;
            r_ty_c   <= ty;
        end
    end

    // sum and saturate
    localparam logic signed [W_SUM-1:0] SAT_HI = W_SUM'({1'b0, {(W_ORG-1){1'b1}}});
    localparam logic signed [W_SUM-1:0] SAT_LO = -SAT_HI - W_SUM'(1);

    logic signed [W_SUM-1:0] ox, oy;
    logic signed [W_ORG-1:0] n_ox, n_oy;

    assign ox = r_bx_c + r_tx_c;
    assign oy = r_by_c + r_ty_c;

    always_comb begin
        priority if (ox > SAT_HI) n_ox = SAT_HI[W_ORG-1:0];
        else if (ox < SAT_LO)     n_ox = SAT_LO[W_ORG-1:0];
        else                      n_ox = ox[W_ORG-1:0];
        priority if (oy > SAT_HI) n_oy = SAT_HI[W_ORG-1:0];
        else if (oy < SAT_LO)     n_oy = SAT_LO[W_ORG-1:0];
        else                      n_oy = oy[W_ORG-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_scale_x     <= r_sx_c;
            o_scale_y     <= r_sy_c;
            o_offset_x    <= n_ox;
            o_offset_y    <= n_oy;
            o_zero_extent <= r_zero_c;
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> hw/rtl/vat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vat_checker
// Port-level checks for the viewbox aspect transform, bound to the top.
// ----------------------------------------------------------------------------
module vat_checker
    import vat_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [W_S-1:0]          o_scale_x,
    input logic signed [W_ORG-1:0] o_offset_x
);

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result dropped");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_scale_x) && $stable(o_offset_x)))
        else $error("stalled result changed");

endmodule

bind viewbox_aspect_transform vat_checker u_vat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_scale_x  (o_scale_x),
    .o_offset_x (o_offset_x)
);
